// ===== rtl/hfd_pkg.sv =====
package hfd_pkg;

  localparam int PREFACE_BYTES = 24;
  localparam int PRE_POS_W     = 5;
  localparam int HDR_POS_W     = 4;
  localparam int LEN_W         = 24;
  localparam int CNT_W         = 32;
  localparam int PEND_W        = LEN_W + 1;

  localparam logic [HDR_POS_W-1:0] HDR_LAST   = HDR_POS_W'(8);
  localparam logic [HDR_POS_W-1:0] IN_PAYLOAD = HDR_POS_W'(9);
  localparam logic [PEND_W-1:0]    HDR_BYTES  = PEND_W'(9);

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_RESET = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_PREFACE  = 3'd0,
    KIND_MATCHED  = 3'd1,
    KIND_REJECTED = 3'd2,
    KIND_HEADER   = 3'd3,
    KIND_PAYLOAD  = 3'd4,
    KIND_CMD_DONE = 3'd5
  } kind_t;

  localparam logic [7:0] PREFACE_TABLE [2**PRE_POS_W] = '{
    8'h50, 8'h52, 8'h49, 8'h20, 8'h2A, 8'h20, 8'h48, 8'h54,
    8'h54, 8'h50, 8'h2F, 8'h32, 8'h2E, 8'h30, 8'h0D, 8'h0A,
    8'h0D, 8'h0A, 8'h53, 8'h4D, 8'h0D, 8'h0A, 8'h0D, 8'h0A,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] in_byte;
    logic       chunk_end;
  } hfd_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [2:0]       byte_kind;
    logic             frame_start;
    logic             frame_last;
    logic [LEN_W-1:0] payload_length;
    logic [CNT_W-1:0] consumed_count;
    logic             count_valid;
  } hfd_result_t;

  typedef struct packed {
    logic vld;
    logic advance;
  } hfd_ctrl_t;

endpackage

// ===== rtl/hfd_if.sv =====
interface hfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, output cmd, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input cmd, input in_byte, input chunk_end, output ready);
endinterface

interface hfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  byte_kind;
  logic        frame_start;
  logic        frame_last;
  logic [23:0] payload_length;
  logic [31:0] consumed_count;
  logic        count_valid;

  modport source (output valid, output out_byte, output byte_kind, output frame_start,
                  output frame_last, output payload_length, output consumed_count,
                  output count_valid, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input frame_start,
                  input frame_last, input payload_length, input consumed_count,
                  input count_valid, output ready);
endinterface

// ===== rtl/hfd_in_reg.sv =====
module hfd_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  hfd_in_if.sink              in_ch,
  input  logic                advance,
  output logic                item_vld,
  output hfd_pkg::hfd_item_t  item
);
  import hfd_pkg::*;

  logic      vld_r;
  hfd_item_t item_r;

  assign in_ch.ready = !vld_r || advance;
  assign item_vld    = vld_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= '{cmd: in_ch.cmd, in_byte: in_ch.in_byte, chunk_end: in_ch.chunk_end};
    end
  end

endmodule

// ===== rtl/hfd_core.sv =====
module hfd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  hfd_pkg::hfd_item_t   item,
  output hfd_pkg::hfd_result_t res
);
  import hfd_pkg::*;

  logic [PRE_POS_W-1:0] pre_pos_r,  pre_pos_nxt;
  logic                 pre_bad_r,  pre_bad_nxt;
  logic                 synced_r,   synced_nxt;
  logic [HDR_POS_W-1:0] hdr_pos_r,  hdr_pos_nxt;
  logic [LEN_W-1:0]     len_r,      len_nxt;
  logic [LEN_W-1:0]     remain_r,   remain_nxt;
  logic [CNT_W-1:0]     consumed_r, consumed_nxt;
  logic [PEND_W-1:0]    pending_r,  pending_nxt;

  logic              bad;
  logic              win_end;
  logic              add_en;
  logic [PEND_W-1:0] add_amt;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  acc;
  logic [LEN_W-1:0]  remain_dec;

  assign bad        = pre_bad_r || (item.in_byte != PREFACE_TABLE[pre_pos_r]);
  assign win_end    = ({1'b0, pre_pos_r} + 1'b1) >= (PRE_POS_W + 1)'(PREFACE_BYTES);
  assign remain_dec = remain_r - 1'b1;
  assign sum        = {1'b0, consumed_r} + (CNT_W + 1)'(add_amt);

  always_comb begin
    pre_pos_nxt  = pre_pos_r;
    pre_bad_nxt  = pre_bad_r;
    synced_nxt   = synced_r;
    hdr_pos_nxt  = hdr_pos_r;
    len_nxt      = len_r;
    remain_nxt   = remain_r;
    consumed_nxt = consumed_r;
    pending_nxt  = pending_r;
    add_en       = 1'b0;
    add_amt      = '0;
    acc          = consumed_r;
    res          = '0;
    res.byte_kind = KIND_CMD_DONE;

    case (item.cmd)
      CMD_FLUSH: begin
        pre_pos_nxt = '0;
        pre_bad_nxt = 1'b0;
        hdr_pos_nxt = '0;
        len_nxt     = '0;
        remain_nxt  = '0;
        pending_nxt = '0;
      end
      CMD_RESET: begin
        pre_pos_nxt  = '0;
        pre_bad_nxt  = 1'b0;
        synced_nxt   = 1'b0;
        hdr_pos_nxt  = '0;
        len_nxt      = '0;
        remain_nxt   = '0;
        consumed_nxt = '0;
        pending_nxt  = '0;
      end
      CMD_DATA: begin
        res.out_byte = item.in_byte;
        if (!synced_r) begin
          if (win_end) begin
            if (!bad) begin
              res.byte_kind = KIND_MATCHED;
              synced_nxt    = 1'b1;
              add_en        = 1'b1;
              add_amt       = PEND_W'(PREFACE_BYTES);
            end else begin
              res.byte_kind = KIND_REJECTED;
            end
            pre_pos_nxt = '0;
            pre_bad_nxt = 1'b0;
          end else begin
            res.byte_kind = KIND_PREFACE;
            pre_pos_nxt   = pre_pos_r + 1'b1;
            pre_bad_nxt   = bad;
          end
        end else if (hdr_pos_r < IN_PAYLOAD) begin
          res.byte_kind = KIND_HEADER;
          if (hdr_pos_r == HDR_POS_W'(0)) begin
            res.frame_start = 1'b1;
            len_nxt         = {item.in_byte, 16'h0000};
          end else if (hdr_pos_r == HDR_POS_W'(1)) begin
            len_nxt = {len_r[23:16], item.in_byte, len_r[7:0]} | len_r;
          end else if (hdr_pos_r == HDR_POS_W'(2)) begin
            len_nxt = len_r | {16'h0000, item.in_byte};
          end
          if (hdr_pos_r == HDR_LAST) begin
            res.payload_length = len_r;
            pending_nxt        = HDR_BYTES + PEND_W'(len_r);
            if (len_r == '0) begin
              res.frame_last = 1'b1;
              add_en         = 1'b1;
              add_amt        = HDR_BYTES;
              hdr_pos_nxt    = '0;
            end else begin
              remain_nxt  = len_r;
              hdr_pos_nxt = IN_PAYLOAD;
            end
          end else begin
            hdr_pos_nxt = hdr_pos_r + 1'b1;
          end
        end else begin
          res.byte_kind      = KIND_PAYLOAD;
          res.payload_length = len_r;
          remain_nxt         = remain_dec;
          if (remain_dec == '0) begin
            res.frame_last = 1'b1;
            add_en         = 1'b1;
            add_amt        = pending_r;
            hdr_pos_nxt    = '0;
          end
        end
        acc = add_en ? (sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0]) : consumed_r;
        consumed_nxt = acc;
        if (item.chunk_end) begin
          res.consumed_count = acc;
          res.count_valid    = 1'b1;
          consumed_nxt       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_pos_r  <= '0;
      pre_bad_r  <= 1'b0;
      synced_r   <= 1'b0;
      hdr_pos_r  <= '0;
      len_r      <= '0;
      remain_r   <= '0;
      consumed_r <= '0;
      pending_r  <= '0;
    end else if (step_en) begin
      pre_pos_r  <= pre_pos_nxt;
      pre_bad_r  <= pre_bad_nxt;
      synced_r   <= synced_nxt;
      hdr_pos_r  <= hdr_pos_nxt;
      len_r      <= len_nxt;
      remain_r   <= remain_nxt;
      consumed_r <= consumed_nxt;
      pending_r  <= pending_nxt;
    end
  end

endmodule

// ===== rtl/hfd_out_reg.sv =====
module hfd_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hfd_pkg::hfd_ctrl_t   ctrl,
  input  hfd_pkg::hfd_result_t res,
  output logic                 out_free,
  hfd_out_if.source            out_ch
);
  import hfd_pkg::*;

  logic        vld_r;
  hfd_result_t res_r;

  assign out_free = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl.advance) begin
      vld_r <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance && ctrl.vld) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.out_byte       = res_r.out_byte;
  assign out_ch.byte_kind      = res_r.byte_kind;
  assign out_ch.frame_start    = res_r.frame_start;
  assign out_ch.frame_last     = res_r.frame_last;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.consumed_count = res_r.consumed_count;
  assign out_ch.count_valid    = res_r.count_valid;

endmodule

// ===== rtl/http2_frame_delimiter.sv =====
// channel   dir  handshake      payload
// in_ch     in   valid/ready    cmd, in_byte, chunk_end
// out_ch    out  valid/ready    out_byte, byte_kind, frame_start, frame_last,
//                               payload_length, consumed_count, count_valid
//
// one item per clock sustained while out_ch is ready; a result passes through the
// input register, then the state update and result register, which load together
// every register in the item path sits in a single-byte step of the deframer
// rst_n synchronous: back to preface hunting with a zero consumed count
// a stalled result register holds the input register, which backs up to in_ch
module http2_frame_delimiter (
  input  logic      clk,
  input  logic      rst_n,
  hfd_in_if.sink    in_ch,
  hfd_out_if.source out_ch
);
  import hfd_pkg::*;

  logic        out_free;
  logic        item_vld;
  hfd_item_t   item;
  hfd_result_t res;
  hfd_ctrl_t   ctrl;

  assign ctrl.vld     = item_vld;
  assign ctrl.advance = out_free;

  hfd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .advance  (out_free),
    .item_vld (item_vld),
    .item     (item)
  );

  hfd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (item_vld && out_free),
    .item    (item),
    .res     (res)
  );

  hfd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== bench/tb_http2_frame_delimiter.sv =====
module tb_http2_frame_delimiter;
  import hfd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int RAND_ITEMS     = 1130;
  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_SHOWN      = 10;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE} phase_t;
  typedef enum {ROW_ONE, ROW_PREFACE, ROW_HEADER, ROW_PAYLOAD} row_kind_t;

  typedef struct {
    hfd_item_t   item;
    bit          typed;
    hfd_result_t res;
  } stim_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  cmd;
    logic [7:0]  data;
    bit          ce;
    int          arg;
    bit          typed;
    hfd_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic hold = 1'b0;

  hfd_in_if  in_ch ();
  hfd_out_if out_ch ();

  http2_frame_delimiter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_t       stim_q [$];
  hfd_result_t result_q [$];
  dir_row_t    dir_tab [18];
  stim_t       cur;
  int          drv_idx = 0;
  int          n_acc = 0;
  int          n_dir = 0;
  int          n_rand = 0;
  int          ce_pct = 0;
  int          n_fail = 0;
  int          n_checked = 0;
  int          n_closed = 0;
  int          n_counts = 0;
  int          n_rejected = 0;
  int          n_matched = 0;
  phase_t      phase;

  // deframer state
  logic [PRE_POS_W-1:0] pf_pos;
  logic                 pf_bad;
  logic                 in_sync;
  logic [HDR_POS_W-1:0] hdr_pos;
  logic [LEN_W-1:0]     frame_len;
  logic [LEN_W-1:0]     pay_left;
  logic [CNT_W-1:0]     chunk_bytes;
  logic [PEND_W-1:0]    frame_bytes;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("tb_http2_frame_delimiter NOT OK");
    $finish;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit in_sync_lost(logic [1:0] cmd);
    return cmd == CMD_RESET;
  endfunction

  function automatic void clear_frame();
    pf_pos      = '0;
    pf_bad      = 1'b0;
    hdr_pos     = '0;
    frame_len   = '0;
    pay_left    = '0;
    frame_bytes = '0;
  endfunction

  function automatic void reset_deframer();
    clear_frame();
    in_sync     = 1'b0;
    chunk_bytes = '0;
  endfunction

  function automatic void add_chunk(logic [PEND_W-1:0] n);
    logic [CNT_W:0] sum;
    sum = {1'b0, chunk_bytes} + (CNT_W + 1)'(n);
    chunk_bytes = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  function automatic hfd_result_t deframe_step(hfd_item_t it);
    hfd_result_t          r;
    logic [PRE_POS_W-1:0] pos;
    logic                 bad;
    r = '0;
    r.byte_kind = KIND_CMD_DONE;
    if (it.cmd == CMD_FLUSH) begin
      clear_frame();
    end else if (it.cmd == CMD_RESET) begin
      reset_deframer();
    end else if (it.cmd == CMD_DATA) begin
      r.out_byte = it.in_byte;
      if (!in_sync) begin
        pos = pf_pos;
        bad = pf_bad || (it.in_byte != PREFACE_TABLE[pos]);
        if (int'(pos) + 1 >= PREFACE_BYTES) begin
          if (!bad) begin
            r.byte_kind = KIND_MATCHED;
            in_sync = 1'b1;
            add_chunk(PEND_W'(PREFACE_BYTES));
          end else begin
            r.byte_kind = KIND_REJECTED;
          end
          pf_pos = '0;
          pf_bad = 1'b0;
        end else begin
          r.byte_kind = KIND_PREFACE;
          pf_pos = pos + 1'b1;
          pf_bad = bad;
        end
      end else if (hdr_pos < IN_PAYLOAD) begin
        r.byte_kind = KIND_HEADER;
        case (hdr_pos)
          0: begin
            r.frame_start = 1'b1;
            frame_len = {it.in_byte, 16'h0000};
          end
          1: frame_len[15:8] = it.in_byte;
          2: frame_len[7:0] = it.in_byte;
          default: ;
        endcase
        if (hdr_pos == HDR_LAST) begin
          r.payload_length = frame_len;
          frame_bytes = HDR_BYTES + PEND_W'(frame_len);
          if (frame_len == '0) begin
            r.frame_last = 1'b1;
            add_chunk(frame_bytes);
            hdr_pos = '0;
          end else begin
            pay_left = frame_len;
            hdr_pos = IN_PAYLOAD;
          end
        end else begin
          hdr_pos = hdr_pos + 1'b1;
        end
      end else begin
        r.byte_kind = KIND_PAYLOAD;
        r.payload_length = frame_len;
        pay_left = pay_left - 1'b1;
        if (pay_left == '0) begin
          r.frame_last = 1'b1;
          add_chunk(frame_bytes);
          hdr_pos = '0;
        end
      end
      if (it.chunk_end) begin
        r.consumed_count = chunk_bytes;
        r.count_valid = 1'b1;
        chunk_bytes = '0;
      end
    end
    return r;
  endfunction

  task automatic push_item(logic [1:0] cmd, logic [7:0] b, bit ce);
    stim_t ent;
    ent.item = '{cmd, b, ce};
    ent.typed = 1'b0;
    ent.res = '0;
    stim_q.push_back(ent);
  endtask

  task automatic push_preface(int bad_pos, bit last_ce);
    logic [7:0] b;
    for (int i = 0; i < PREFACE_BYTES; i++) begin
      b = PREFACE_TABLE[i];
      if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      push_item(CMD_DATA, b, (i == PREFACE_BYTES - 1) ? last_ce : chance(ce_pct));
    end
  endtask

  task automatic push_header(logic [LEN_W-1:0] len);
    push_item(CMD_DATA, len[23:16], chance(ce_pct));
    push_item(CMD_DATA, len[15:8], chance(ce_pct));
    push_item(CMD_DATA, len[7:0], chance(ce_pct));
    repeat (6) push_item(CMD_DATA, 8'($urandom), chance(ce_pct));
  endtask

  task automatic push_payload(int n, bit last_ce);
    for (int i = 0; i < n; i++)
      push_item(CMD_DATA, 8'($urandom), chance(ce_pct) || (last_ce && i == n - 1));
  endtask

  always_comb begin
    if (n_rand == 0 || drv_idx < n_dir) begin
      phase = PH_FREE;
    end else begin
      case (((drv_idx - n_dir) * 5) / n_rand)
        0: phase = PH_FREE;
        1: phase = PH_SEND_IDLE;
        2: phase = PH_RECV_STALL;
        3: phase = PH_BOTH;
        default: phase = PH_PRESSURE;
      endcase
    end
  end

  // input side
  always @(posedge clk) begin
    bit          take;
    hfd_result_t pred;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      take = !in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        pred = deframe_step(cur.item);
        result_q.push_back(cur.typed ? cur.res : pred);
        n_acc++;
        take = 1'b1;
      end
      if (take) begin
        if (drv_idx < stim_q.size() &&
            !((phase == PH_SEND_IDLE && chance(65)) || (phase == PH_BOTH && chance(18)))) begin
          cur = stim_q[drv_idx];
          in_ch.valid     <= 1'b1;
          in_ch.cmd       <= cur.item.cmd;
          in_ch.in_byte   <= cur.item.in_byte;
          in_ch.chunk_end <= cur.item.chunk_end;
          drv_idx <= drv_idx + 1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off on the result side
  initial begin
    wait (phase == PH_PRESSURE);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  // result side
  always @(posedge clk) begin
    hfd_result_t got;
    hfd_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte       = out_ch.out_byte;
        got.byte_kind      = out_ch.byte_kind;
        got.frame_start    = out_ch.frame_start;
        got.frame_last     = out_ch.frame_last;
        got.payload_length = out_ch.payload_length;
        got.consumed_count = out_ch.consumed_count;
        got.count_valid    = out_ch.count_valid;
        if (result_q.size() == 0) begin
          if (n_fail < MAX_SHOWN)
            $display("unexpected item: byte=%h kind=%0d", got.out_byte, got.byte_kind);
          n_fail++;
        end else begin
          want = result_q.pop_front();
          n_checked++;
          if (got.out_byte !== want.out_byte || got.byte_kind !== want.byte_kind ||
              got.frame_start !== want.frame_start || got.frame_last !== want.frame_last ||
              got.payload_length !== want.payload_length ||
              got.consumed_count !== want.consumed_count ||
              got.count_valid !== want.count_valid) begin
            if (n_fail < MAX_SHOWN) begin
              $display("mismatch at item %0d: exp byte=%h kind=%0d s=%b l=%b len=%h cnt=%h v=%b",
                       n_checked, want.out_byte, want.byte_kind, want.frame_start,
                       want.frame_last, want.payload_length, want.consumed_count,
                       want.count_valid);
              $display("                  got byte=%h kind=%0d s=%b l=%b len=%h cnt=%h v=%b",
                       got.out_byte, got.byte_kind, got.frame_start, got.frame_last,
                       got.payload_length, got.consumed_count, got.count_valid);
            end
            n_fail++;
          end
          if (want.frame_last) n_closed++;
          if (want.count_valid) n_counts++;
          if (want.byte_kind == KIND_REJECTED) n_rejected++;
          if (want.byte_kind == KIND_MATCHED) n_matched++;
        end
      end
      out_ch.ready <= !hold &&
                      !((phase == PH_RECV_STALL && chance(65)) || (phase == PH_BOTH && chance(18)));
    end
  end

  initial begin
    stim_t            ent;
    int               pick;
    int               sel;
    int               pay;
    logic [LEN_W-1:0] len;

    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_DATA;
    in_ch.in_byte   = 8'h00;
    in_ch.chunk_end = 1'b0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    reset_deframer();

    dir_tab = '{
      '{ROW_ONE, CMD_DATA, 8'h00, 1'b1, 0, 1'b1,
        '{8'h00, KIND_PREFACE, 1'b0, 1'b0, 24'h0, 32'h0, 1'b1}},
      '{ROW_ONE, CMD_FLUSH, 8'h00, 1'b1, 0, 1'b1,
        '{8'h00, KIND_CMD_DONE, 1'b0, 1'b0, 24'h0, 32'h0, 1'b0}},
      '{ROW_ONE, CMD_UNUSED, 8'hFF, 1'b1, 0, 1'b1,
        '{8'h00, KIND_CMD_DONE, 1'b0, 1'b0, 24'h0, 32'h0, 1'b0}},
      '{ROW_ONE, CMD_DATA, 8'hFF, 1'b0, 0, 1'b1,
        '{8'hFF, KIND_PREFACE, 1'b0, 1'b0, 24'h0, 32'h0, 1'b0}},
      '{ROW_ONE, CMD_RESET, 8'h00, 1'b0, 0, 1'b1,
        '{8'h00, KIND_CMD_DONE, 1'b0, 1'b0, 24'h0, 32'h0, 1'b0}},
      '{ROW_PREFACE, CMD_DATA, 8'h00, 1'b0, 0, 1'b0, '0},
      '{ROW_PREFACE, CMD_DATA, 8'h00, 1'b0, PREFACE_BYTES - 1, 1'b0, '0},
      '{ROW_PREFACE, CMD_DATA, 8'h00, 1'b1, -1, 1'b0, '0},
      '{ROW_HEADER, CMD_DATA, 8'h00, 1'b0, 0, 1'b0, '0},
      '{ROW_HEADER, CMD_DATA, 8'h00, 1'b0, 16777215, 1'b0, '0},
      '{ROW_PAYLOAD, CMD_DATA, 8'h00, 1'b0, 3, 1'b0, '0},
      '{ROW_ONE, CMD_FLUSH, 8'h00, 1'b1, 0, 1'b0, '0},
      '{ROW_HEADER, CMD_DATA, 8'h00, 1'b0, 1, 1'b0, '0},
      '{ROW_PAYLOAD, CMD_DATA, 8'h00, 1'b1, 1, 1'b0, '0},
      '{ROW_HEADER, CMD_DATA, 8'h00, 1'b0, 2, 1'b0, '0},
      '{ROW_PAYLOAD, CMD_DATA, 8'h00, 1'b0, 1, 1'b0, '0},
      '{ROW_ONE, CMD_RESET, 8'h00, 1'b1, 0, 1'b0, '0},
      '{ROW_ONE, CMD_DATA, 8'h50, 1'b1, 0, 1'b0, '0}
    };

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_ONE: begin
          ent.item  = '{dir_tab[i].cmd, dir_tab[i].data, dir_tab[i].ce};
          ent.typed = dir_tab[i].typed;
          ent.res   = dir_tab[i].res;
          stim_q.push_back(ent);
        end
        ROW_PREFACE: push_preface(dir_tab[i].arg, dir_tab[i].ce);
        ROW_HEADER:  push_header(LEN_W'(dir_tab[i].arg));
        default:     push_payload(dir_tab[i].arg, dir_tab[i].ce);
      endcase
    end
    n_dir = stim_q.size();

    ce_pct = 8;
    push_item(CMD_RESET, 8'($urandom), chance(50));
    push_preface(-1, chance(ce_pct));
    while (stim_q.size() - n_dir < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        push_item(CMD_RESET, 8'($urandom), chance(50));
        push_preface(chance(85) ? -1 : $urandom_range(0, PREFACE_BYTES - 1), chance(ce_pct));
      end else if (pick < 8) begin
        push_item(CMD_FLUSH, 8'($urandom), chance(50));
      end else if (pick < 10) begin
        push_item(chance(50) ? CMD_UNUSED : CMD_DATA, 8'($urandom), chance(50));
      end else if (pick < 12) begin
        // garbage while hunting, then sync again
        push_item(CMD_RESET, 8'($urandom), chance(50));
        push_payload($urandom_range(1, 60), 1'b0);
        push_item(CMD_RESET, 8'($urandom), 1'b0);
        push_preface(-1, chance(ce_pct));
      end else begin
        sel = $urandom_range(99);
        if (sel < 10) len = '0;
        else if (sel < 70) len = LEN_W'($urandom_range(1, 16));
        else if (sel < 95) len = LEN_W'($urandom_range(17, 120));
        else len = LEN_W'($urandom);
        push_header(len);
        if (len > 120 || (len != '0 && chance(8))) begin
          pay = (len > 120) ? $urandom_range(0, 20) : $urandom_range(0, int'(len) - 1);
          push_payload(pay, 1'b0);
          push_item(chance(80) ? CMD_FLUSH : CMD_RESET, 8'($urandom), chance(ce_pct));
          if (in_sync_lost(stim_q[stim_q.size() - 1].item.cmd))
            push_preface(-1, chance(ce_pct));
        end else begin
          push_payload(int'(len), 1'b0);
        end
      end
    end
    n_rand = stim_q.size() - n_dir;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_acc == stim_q.size());
    wait (result_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_q.size() != 0) n_fail++;

    $display("sent %0d items (%0d directed), checked %0d results", n_acc, n_dir, n_checked);
    $display("frames closed %0d, chunk counts %0d, prefaces matched %0d, rejected %0d",
             n_closed, n_counts, n_matched, n_rejected);
    if (n_fail == 0) begin
      $display("tb_http2_frame_delimiter OK");
    end else begin
      $display("tb_http2_frame_delimiter NOT OK");
    end
    $finish;
  end

endmodule
